// ===== src/slcd_pkg.sv =====
package slcd_pkg;

    // Register map
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic        REG_START_BYTE = 1'b0;   // register index 0

    localparam logic [7:0] START_RESET  = 8'h16;
    localparam logic [1:0] HEADER_BYTES = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       first_byte;
        logic       last_byte;
        logic       checksum_ok;
    } t_frame_item;

    typedef struct packed {
        logic        valid;
        t_frame_item item;
    } t_result;

endpackage

// ===== src/slcd_rx_if.sv =====
interface slcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/slcd_frame_if.sv =====
interface slcd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       first_byte;
    logic       last_byte;
    logic       checksum_ok;

    modport source (
        output valid, output frame_byte, output first_byte,
        output last_byte, output checksum_ok, input ready
    );
    modport sink (
        input valid, input frame_byte, input first_byte,
        input last_byte, input checksum_ok, output ready
    );
endinterface

// ===== src/start_length_checksum_deframer.sv =====
// Frame finder for a received byte stream.
// Input channel i_rx carries one received byte per item. Bytes are dropped
// until one equals the start byte register; then the start byte, two header
// bytes, a length byte N, N payload bytes and a checksum byte (N+5 bytes)
// each go out as one item on o_frame, with first_byte on the start byte and
// last_byte on the checksum byte. checksum_ok is set on the last byte when
// the 8-bit sum of header, length and payload bytes equals the checksum.
// Latency: an accepted byte appears on o_frame in the next cycle.
// Throughput: one byte per cycle while o_frame.ready is high; the frame state update (phase, counters,
// running sum) sits between the state registers and the output register.
// Stall: the output register holds its item while o_frame.ready is low, and
// i_rx.ready stays high only while that register is empty or being drained.
// Reset (synchronous, active low): hunting for a start byte, output empty,
// start byte register back to 0x16.
// Config: APB, start_byte at address 0; write it only while the block idles.
module start_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slcd_rx_if.sink               i_rx,
    slcd_frame_if.source          o_frame,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---- configuration ----
    logic [7:0] r_start_byte;
    logic       cfg_sel_start;

    // register index is the top address bit
    assign cfg_sel_start = (paddr[CFG_ADDR_W-1] == REG_START_BYTE);
    assign pready        = 1'b1;
    assign prdata        = cfg_sel_start ? {{(CFG_DATA_W-8){1'b0}}, r_start_byte}
                                         : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
        end else if (psel && penable && pwrite && cfg_sel_start) begin
            r_start_byte <= pwdata[7:0];
        end
    end

    // ---- frame state and per-byte decision ----
    logic        rx_accept;
    t_result     result;
    logic        r_out_valid, n_out_valid;
    t_frame_item r_out_item;

    assign i_rx.ready = !r_out_valid || o_frame.ready;
    assign rx_accept  = i_rx.valid && i_rx.ready;

    slcd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (rx_accept),
        .i_byte       (i_rx.rx_byte),
        .i_start_byte (r_start_byte),
        .o_result     (result)
    );

    // ---- output register ----
    always_comb begin
        n_out_valid = r_out_valid;
        if (rx_accept) begin
            n_out_valid = result.valid;     // a hunted-over byte leaves it empty
        end else if (o_frame.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept && result.valid) begin
            r_out_item <= result.item;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.frame_byte  = r_out_item.frame_byte;
    assign o_frame.first_byte  = r_out_item.first_byte;
    assign o_frame.last_byte   = r_out_item.last_byte;
    assign o_frame.checksum_ok = r_out_item.checksum_ok;

`ifndef SYNTHESIS
    // a held item must block the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |-> !i_rx.ready)
        else $error("input accepted while output item is stalled");

    // a frame byte is never both first and last
    a_first_last_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |-> !(o_frame.first_byte && o_frame.last_byte))
        else $error("item marked both first and last");

    // checksum status only rides on the closing byte
    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.checksum_ok) |-> o_frame.last_byte)
        else $error("checksum_ok set on a non-final byte");

    // a stalled output with no new acceptance keeps its item
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("stalled output item changed");
`endif

endmodule

// ===== src/slcd_parser.sv =====
module slcd_parser
    import slcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_start_byte,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_header_count, n_header_count;
    logic [7:0] r_payload_left, n_payload_left;
    logic [7:0] r_sum, n_sum;

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_payload_left = r_payload_left;
        n_sum          = r_sum;
        case (r_phase)
            PH_HEADER: begin
                n_sum          = r_sum + i_byte;
                n_header_count = r_header_count + 2'd1;
                if (n_header_count >= HEADER_BYTES) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_sum          = r_sum + i_byte;
                n_payload_left = i_byte;
                n_phase        = (i_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                n_sum          = r_sum + i_byte;
                n_payload_left = r_payload_left - 8'd1;
                if (n_payload_left == 8'd0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase        = PH_HUNT;
                n_header_count = 2'd0;
                n_payload_left = 8'd0;
                n_sum          = 8'd0;
            end
            default: begin
                // hunting; unused codes fall back here too
                n_phase = PH_HUNT;
                if (i_byte == i_start_byte) begin
                    n_phase        = PH_HEADER;
                    n_header_count = 2'd0;
                    n_payload_left = 8'd0;
                    n_sum          = 8'd0;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_result.valid            = 1'b1;
        o_result.item.frame_byte  = i_byte;
        o_result.item.first_byte  = 1'b0;
        o_result.item.last_byte   = 1'b0;
        o_result.item.checksum_ok = 1'b0;
        case (r_phase)
            PH_HEADER, PH_LENGTH, PH_PAYLOAD: begin
                o_result.valid = 1'b1;
            end
            PH_CHECK: begin
                o_result.item.last_byte   = 1'b1;
                o_result.item.checksum_ok = (r_sum == i_byte);
            end
            default: begin
                o_result.valid           = (i_byte == i_start_byte);
                o_result.item.first_byte = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_header_count <= 2'd0;
            r_payload_left <= 8'd0;
            r_sum          <= 8'd0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_payload_left <= n_payload_left;
            r_sum          <= n_sum;
        end
    end

endmodule
